### rtl/core/skt_pkg.sv
package skt_pkg;

	localparam logic [2:0] MODE_INSERT = 3'd0;
	localparam logic [2:0] MODE_REMOVE = 3'd1;
	localparam logic [2:0] MODE_QUERY  = 3'd2;
	localparam logic [2:0] MODE_POP    = 3'd3;
	localparam logic [2:0] MODE_READ   = 3'd4;

	typedef struct packed {
		logic [2:0]         mode;
		logic signed [31:0] key;
	} in_t;

	typedef struct packed {
		logic               found;
		logic [4:0]         count;
		logic signed [31:0] smallest_key;
		logic               dropped;
	} out_t;

	typedef struct packed {
		logic               ins;
		logic               rem;
		logic               pop;
		logic signed [31:0] key;
	} ctrl_t;

endpackage

### rtl/core/skt_cell.sv
module skt_cell (
	input  logic                 clk,
	input  skt_pkg::ctrl_t       ctrl,
	input  logic                 occ,
	input  logic                 left_gt,
	input  logic signed [31:0]   left_key,
	input  logic signed [31:0]   right_key,
	output logic signed [31:0]   key_q,
	output logic signed [31:0]   key_d,
	output logic                 gt,
	output logic                 eq
);
	import skt_pkg::*;

	logic ge;

	assign gt = occ && (key_q > ctrl.key);
	assign ge = occ && !(key_q < ctrl.key);
	assign eq = occ && (key_q == ctrl.key);

	always_comb begin
		key_d = key_q;
		if (ctrl.ins) begin
			if (left_gt) begin
				key_d = left_key;
			end else if (gt || !occ) begin
				key_d = ctrl.key;
			end
		end else if (ctrl.pop || (ctrl.rem && ge)) begin
			key_d = right_key;
		end
	end

	always_ff @(posedge clk) begin
		key_q <= key_d;
	end

endmodule

### rtl/core/sorted_key_table_top.sv
// Channel | Transfer when          | Payload
// in      | in_valid & in_ready    | in_data  (mode, key)
// out     | out_valid & out_ready  | out_data (found, count, smallest_key, dropped)
//
// One item per cycle: every cell of the row compares its key with the item key and
// loads itself, its left or its right neighbor in the same cycle; the match OR tree
// and the count update share that cycle, and the result lands in the output register.
// Reset clears the count and the output valid; cell contents need no clearing.
// in_ready = !out_valid | out_ready, so a stalled result stalls only new items.
module sorted_key_table_top #(
	parameter int CAPACITY = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  skt_pkg::in_t   in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output skt_pkg::out_t  out_data
);
	import skt_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	logic [CW-1:0]      held_q, held_d;
	logic               out_valid_q;
	out_t               out_q;
	logic               accept, full, found_any;
	ctrl_t              ctrl;
	logic [CAPACITY-1:0] occ, gt, eq;
	logic signed [31:0] key_q [CAPACITY];
	logic signed [31:0] key_d [CAPACITY];

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign full      = (held_q == CW'(CAPACITY));
	assign found_any = |eq;

	assign ctrl.key = in_data.key;
	assign ctrl.ins = accept && (in_data.mode == MODE_INSERT) && !full;
	assign ctrl.rem = accept && (in_data.mode == MODE_REMOVE) && found_any;
	assign ctrl.pop = accept && (in_data.mode == MODE_POP) && (held_q != '0);

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic               lgt;
			logic signed [31:0] lkey, rkey;
			assign occ[i] = (CW'(i) < held_q);
			if (i == 0) begin : g_first
				assign lgt  = 1'b0;
				assign lkey = key_q[i];
			end else begin : g_mid
				assign lgt  = gt[i-1];
				assign lkey = key_q[i-1];
			end
			if (i == CAPACITY - 1) begin : g_last
				assign rkey = key_q[i];
			end else begin : g_inner
				assign rkey = key_q[i+1];
			end
			skt_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.occ       (occ[i]),
				.left_gt   (lgt),
				.left_key  (lkey),
				.right_key (rkey),
				.key_q     (key_q[i]),
				.key_d     (key_d[i]),
				.gt        (gt[i]),
				.eq        (eq[i])
			);
		end
	endgenerate

	always_comb begin
		held_d = held_q;
		if (ctrl.ins) begin
			held_d = held_q + CW'(1);
		end else if (ctrl.rem || ctrl.pop) begin
			held_d = held_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				held_q <= held_d;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.found        <= ((in_data.mode == MODE_REMOVE) ||
				(in_data.mode == MODE_QUERY)) ? found_any : ctrl.pop;
			out_q.count        <= 5'(held_d);
			out_q.smallest_key <= (held_d != '0) ? key_d[0] : 32'sd0;
			out_q.dropped      <= (in_data.mode == MODE_INSERT) && full;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_held_range: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(CAPACITY))
		else $error("held count beyond capacity");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.dropped |-> held_q == CW'(CAPACITY))
		else $error("insert dropped while table not full");

	a_found_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.found && out_q.dropped))
		else $error("found and dropped together");

	generate
		for (i = 0; i + 1 < CAPACITY; i++) begin : g_chk
			a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
				occ[i+1] |-> key_q[i] <= key_q[i+1])
				else $error("cell row out of order");
		end
	endgenerate

endmodule

### sim/skt_result_checker.sv
module skt_result_checker #(
	parameter int CAPACITY = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          in_ready,
	input  skt_pkg::in_t  in_data,
	input  logic          out_valid,
	input  logic          out_ready,
	input  skt_pkg::out_t out_data,
	output int            errors,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import skt_pkg::*;

	logic signed [31:0] shadow_keys [CAPACITY];
	int                 shadow_count;
	out_t               expected_results [$];
	out_t               want;
	int                 error_count = 0;
	int                 pending_count = 0;

	assign errors  = error_count;
	assign pending = pending_count;

	task automatic report_mismatch(input string msg);
		$display("%0t ns: mismatch: %s", $time, msg);
		error_count++;
	endtask

	function automatic int find_key_pos(input logic signed [31:0] k);
		int i;
		for (i = 0; i < shadow_count; i++) begin
			if (shadow_keys[i] == k)
				return i;
		end
		return shadow_count;
	endfunction

	function automatic void delete_entry(input int pos);
		int i;
		for (i = pos; i + 1 < shadow_count; i++)
			shadow_keys[i] = shadow_keys[i + 1];
		shadow_count--;
	endfunction

	function automatic out_t apply_table_op(input in_t item);
		out_t               res;
		logic signed [31:0] k;
		int                 pos;
		int                 i;
		res = '0;
		k = item.key;
		pos = 0;
		case (item.mode)
		MODE_INSERT: begin
			if (shadow_count >= CAPACITY) begin
				res.dropped = 1'b1;
			end else begin
				// equal keys stay ahead of the new one
				while (pos < shadow_count && shadow_keys[pos] <= k)
					pos++;
				for (i = shadow_count; i > pos; i--)
					shadow_keys[i] = shadow_keys[i - 1];
				shadow_keys[pos] = k;
				shadow_count++;
			end
		end
		MODE_REMOVE: begin
			pos = find_key_pos(k);
			if (pos < shadow_count) begin
				delete_entry(pos);
				res.found = 1'b1;
			end
		end
		MODE_QUERY: begin
			res.found = (find_key_pos(k) < shadow_count);
		end
		MODE_POP: begin
			if (shadow_count > 0) begin
				delete_entry(0);
				res.found = 1'b1;
			end
		end
		default: begin
		end
		endcase
		res.count = 5'(shadow_count);
		res.smallest_key = (shadow_count > 0) ? shadow_keys[0] : '0;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_results.delete();
			shadow_count = 0;
			pending_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (out_data.found !== want.found)
						report_mismatch($sformatf("found got %0b want %0b",
							out_data.found, want.found));
					if (out_data.count !== want.count)
						report_mismatch($sformatf("count got %0d want %0d",
							out_data.count, want.count));
					if (out_data.smallest_key !== want.smallest_key)
						report_mismatch($sformatf("smallest_key got %0d want %0d",
							out_data.smallest_key, want.smallest_key));
					if (out_data.dropped !== want.dropped)
						report_mismatch($sformatf("dropped got %0b want %0b",
							out_data.dropped, want.dropped));
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(apply_table_op(in_data));
			pending_count <= expected_results.size();
		end
	end

endmodule

### sim/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import skt_pkg::*;

	localparam int         CAPACITY     = 16;
	localparam int         ITEMS        = 1150;
	localparam int         QUIET_ITEMS  = 120;
	localparam int         STALL_AT     = 300;
	localparam int         STALL_CYCLES = 200;
	localparam int         IDLE_LIMIT   = 1000;
	localparam logic [2:0] MODE_SPARE_5 = 3'd5;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;
	localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

	logic  clk;
	logic  arst_n;
	logic  in_valid;
	logic  in_ready;
	in_t   in_data;
	logic  out_valid;
	logic  out_ready;
	out_t  out_data;
	int    errors;
	int    pending;
	int    sent_count = 0;
	int    idle_cycles = 0;
	bit    quiet = 0;
	bit    pressured = 0;

	sorted_key_table_top #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	skt_result_checker #(
		.CAPACITY(CAPACITY)
	) chk (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.errors   (errors),
		.pending  (pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic offer(input logic [2:0] mode, input logic signed [31:0] key);
		in_t item;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		item.mode = mode;
		item.key = key;
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent_count++;
		if (sent_count >= ITEMS - QUIET_ITEMS)
			quiet = 1;
	endtask

	function automatic logic [2:0] pick_mode(input int insert_pct);
		int r;
		if ($urandom_range(0, 99) < insert_pct)
			return MODE_INSERT;
		r = $urandom_range(0, 19);
		if (r < 7)
			return MODE_REMOVE;
		if (r < 12)
			return MODE_QUERY;
		if (r < 17)
			return MODE_POP;
		if (r == 18)
			return 3'($urandom_range(MODE_SPARE_5, MODE_SPARE_7));
		return MODE_READ;
	endfunction

	function automatic logic signed [31:0] pick_key();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return 32'($signed($urandom_range(0, 15)) - 8);
		if (r == 6) begin
			case ($urandom_range(0, 3))
			0: return KEY_MIN;
			1: return KEY_MAX;
			2: return '0;
			default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	initial begin
		int i;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(MODE_READ, 32'sd0);
		offer(MODE_POP, 32'sd0);
		offer(MODE_REMOVE, 32'sd5);
		offer(MODE_QUERY, 32'sd5);
		offer(MODE_SPARE_7, KEY_MAX);
		offer(MODE_INSERT, KEY_MAX);
		offer(MODE_INSERT, KEY_MIN);
		offer(MODE_INSERT, 32'sd0);
		offer(MODE_INSERT, -32'sd1);
		offer(MODE_INSERT, 32'sd5);
		offer(MODE_INSERT, 32'sd5);
		offer(MODE_INSERT, 32'sd5);
		offer(MODE_INSERT, -32'sd7);
		offer(MODE_INSERT, 32'sd1);
		offer(MODE_INSERT, 32'sd100);
		offer(MODE_INSERT, -32'sd100);
		offer(MODE_INSERT, 32'sh4000_0000);
		offer(MODE_INSERT, 32'sd5);
		offer(MODE_INSERT, -32'sd1);
		offer(MODE_INSERT, 32'sd7);
		offer(MODE_INSERT, 32'sd3);
		offer(MODE_INSERT, 32'sd9);
		offer(MODE_QUERY, 32'sd100);
		offer(MODE_REMOVE, 32'sd5);
		offer(MODE_POP, 32'sd0);
		offer(MODE_SPARE_5, KEY_MIN);
		offer(MODE_SPARE_6, 32'sd5);

		// alternate fill-heavy and drain-heavy stretches
		i = 0;
		while (sent_count < ITEMS) begin
			offer(pick_mode(((i / 64) % 2 == 0) ? 75 : 20), pick_key());
			i++;
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

	initial begin
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (!pressured && sent_count >= STALL_AT) begin
				// hold off long enough for the input side to back up
				pressured = 1;
				out_ready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_top failed");
				$finish;
			end
		end
	end

endmodule

### filelist.f
rtl/core/skt_pkg.sv
rtl/core/skt_cell.sv
rtl/core/sorted_key_table_top.sv
sim/skt_result_checker.sv
sim/tb_top.sv
